/* src/cpu_data_transfer_unit_macros.svh */
// Assertion helpers for the data transfer unit.
`ifndef CPU_DATA_TRANSFER_UNIT_MACROS_SVH
`define CPU_DATA_TRANSFER_UNIT_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define CDTU_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("cdtu assertion failed");

// Next-cycle implication, off while reset is asserted.
`define CDTU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("cdtu assertion failed");

`endif

/* src/cdtu_pkg.sv */
package cdtu_pkg;

	// data memory, depth is a power of two so the address wraps by truncation
	localparam int MEM_DEPTH = 4096;
	localparam int MEM_AW    = $clog2(MEM_DEPTH);

	typedef logic [MEM_AW-1:0] maddr_t;

	typedef enum logic [3:0] {
		OP_MOV  = 4'd0,
		OP_MVI  = 4'd1,
		OP_LDA  = 4'd2,
		OP_STA  = 4'd3,
		OP_LDAX = 4'd4,
		OP_STAX = 4'd5,
		OP_LXI  = 4'd6,
		OP_LHLD = 4'd7,
		OP_SHLD = 4'd8,
		OP_XCHG = 4'd9,
		OP_OUT  = 4'd10,
		OP_IN   = 4'd11,
		OP_HLT  = 4'd12
	} op_t;

	typedef enum logic [1:0] {
		ST_RUN   = 2'd0,
		ST_HALT  = 2'd1,
		ST_FAULT = 2'd2
	} status_t;

	localparam logic [2:0] R_A = 3'd0;
	localparam logic [2:0] R_B = 3'd1;
	localparam logic [2:0] R_C = 3'd2;
	localparam logic [2:0] R_D = 3'd3;
	localparam logic [2:0] R_E = 3'd4;
	localparam logic [2:0] R_H = 3'd5;
	localparam logic [2:0] R_L = 3'd6;
	localparam logic [2:0] R_M = 3'd7;

	localparam logic [2:0] PAIR_BC = 3'd0;
	localparam logic [2:0] PAIR_DE = 3'd1;
	localparam logic [2:0] PAIR_HL = 3'd2;
	localparam logic [2:0] PAIR_SP = 3'd3;

	typedef struct packed {
		logic [7:0] a;
		logic [7:0] b;
		logic [7:0] c;
		logic [7:0] d;
		logic [7:0] e;
		logic [7:0] h;
		logic [7:0] l;
	} gpr_t;

	typedef struct packed {
		logic       en;
		logic       we;
		maddr_t     addr;
		logic [7:0] wdata;
	} mem_req_t;

	function automatic maddr_t mem_idx(logic [15:0] addr16);
		return addr16[MEM_AW-1:0];
	endfunction

	// M reads as zero here; memory operands are handled by the caller
	function automatic logic [7:0] get_reg(gpr_t r, logic [2:0] code);
		logic [7:0] v;
		case (code)
			R_A:     v = r.a;
			R_B:     v = r.b;
			R_C:     v = r.c;
			R_D:     v = r.d;
			R_E:     v = r.e;
			R_H:     v = r.h;
			R_L:     v = r.l;
			default: v = 8'h00;
		endcase
		return v;
	endfunction

	function automatic gpr_t put_reg(gpr_t r, logic [2:0] code, logic [7:0] v);
		gpr_t n;
		n = r;
		case (code)
			R_A:     n.a = v;
			R_B:     n.b = v;
			R_C:     n.c = v;
			R_D:     n.d = v;
			R_E:     n.e = v;
			R_H:     n.h = v;
			R_L:     n.l = v;
			default: n = r;
		endcase
		return n;
	endfunction

endpackage

/* src/cdtu_ifs.sv */
interface cdtu_instr_if;
	logic        valid;
	logic        ready;
	logic [3:0]  op;
	logic [2:0]  dest_reg;
	logic [2:0]  src_reg;
	logic [2:0]  reg_pair;
	logic [15:0] immediate;

	modport source (output valid, op, dest_reg, src_reg, reg_pair, immediate, input ready);
	modport sink (input valid, op, dest_reg, src_reg, reg_pair, immediate, output ready);
endinterface

interface cdtu_result_if;
	logic        valid;
	logic        ready;
	logic [7:0]  reg_a;
	logic [7:0]  reg_b;
	logic [7:0]  reg_c;
	logic [7:0]  reg_d;
	logic [7:0]  reg_e;
	logic [7:0]  reg_h;
	logic [7:0]  reg_l;
	logic [15:0] stack_ptr;
	logic [1:0]  status;

	modport source (output valid, reg_a, reg_b, reg_c, reg_d, reg_e, reg_h, reg_l,
		stack_ptr, status, input ready);
	modport sink (input valid, reg_a, reg_b, reg_c, reg_d, reg_e, reg_h, reg_l,
		stack_ptr, status, output ready);
endinterface

/* src/cpu_data_transfer_unit.sv */
// Channel  Role    Payload
// -------  ------  ----------------------------------------------------------
// instr    sink    op, dest_reg, src_reg, reg_pair, immediate
// result   source  reg_a .. reg_l, stack_ptr, status (one word per instruction)
//
// One instruction word per cycle unless stalled; LHLD and SHLD hold the single
// memory port for a second access and block new words meanwhile. A result is
// registered as its word leaves the execute stage (LHLD: after its high byte).
// After reset a zero sweep over all 4096 data memory entries runs with
// instr.ready low.
// A result held by result.ready low stalls the execute stage; one further
// word may still be accepted into an empty execute stage.
module cpu_data_transfer_unit (
	input logic           clk,
	input logic           arst_n,
	cdtu_instr_if.sink    instr,
	cdtu_result_if.source result
);
	import cdtu_pkg::*;

	// architectural state
	gpr_t        gpr_q;
	logic [15:0] sp_q;
	status_t     st_q;

	// execute stage: the word whose first memory access went out at accept
	logic        vld_s1;
	logic        ph_s1;       // LHLD: second byte pending
	logic [3:0]  op_s1;
	logic [2:0]  dst_s1;
	logic [2:0]  src_s1;
	logic [2:0]  pair_s1;
	logic [15:0] imm_s1;

	// output register
	logic        out_vld_q;
	gpr_t        out_gpr_q;
	logic [15:0] out_sp_q;
	status_t     out_st_q;

	// execute results
	gpr_t        gpr_n;
	logic [15:0] sp_n;
	status_t     st_n;
	logic        s1_last;     // this cycle ends the instruction
	logic        port_busy;   // execute stage needs the memory port this cycle
	mem_req_t    m2_req;      // second access of LHLD / SHLD

	logic        s1_done;
	logic        s1_adv;
	logic        in_ready;
	logic        accept;
	mem_req_t    m1_req;      // first access of the incoming word
	mem_req_t    mreq;
	logic [7:0]  mrdata;
	logic        clr_busy;

	cdtu_dmem u_dmem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.rdata  (mrdata),
		.busy   (clr_busy)
	);

	// ---------------------------------------------------------------------
	// execute: memory read data of the word in s1 is valid in this cycle
	// ---------------------------------------------------------------------
	always_comb begin
		logic [7:0] mv_val;
		gpr_n     = gpr_q;
		sp_n      = sp_q;
		st_n      = st_q;
		s1_last   = 1'b1;
		port_busy = 1'b0;
		m2_req    = '0;
		mv_val    = (src_s1 == R_M) ? mrdata : get_reg(gpr_q, src_s1);
		if (vld_s1 && st_q == ST_RUN) begin
			case (op_t'(op_s1))
				OP_MOV: begin
					if (dst_s1 != src_s1 && dst_s1 != R_M) begin
						gpr_n = put_reg(gpr_q, dst_s1, mv_val);
					end
				end
				OP_MVI: begin
					if (dst_s1 != R_M) begin
						gpr_n = put_reg(gpr_q, dst_s1, imm_s1[7:0]);
					end
				end
				OP_LDA, OP_IN: begin
					gpr_n.a = mrdata;
				end
				OP_LDAX: begin
					if (pair_s1 inside {PAIR_BC, PAIR_DE}) begin
						gpr_n.a = mrdata;
					end
				end
				OP_LXI: begin
					case (pair_s1)
						PAIR_BC: begin
							gpr_n.b = imm_s1[15:8];
							gpr_n.c = imm_s1[7:0];
						end
						PAIR_DE: begin
							gpr_n.d = imm_s1[15:8];
							gpr_n.e = imm_s1[7:0];
						end
						PAIR_HL: begin
							gpr_n.h = imm_s1[15:8];
							gpr_n.l = imm_s1[7:0];
						end
						PAIR_SP: begin
							sp_n = imm_s1;
						end
						default: begin
							sp_n = sp_q;
						end
					endcase
				end
				OP_LHLD: begin
					if (!ph_s1) begin
						// low byte in, fetch high byte at imm+1
						gpr_n.l      = mrdata;
						s1_last      = 1'b0;
						port_busy    = 1'b1;
						m2_req.en    = 1'b1;
						m2_req.we    = 1'b0;
						m2_req.addr  = mem_idx(imm_s1 + 16'd1);
					end else begin
						gpr_n.h = mrdata;
					end
				end
				OP_SHLD: begin
					port_busy    = 1'b1;
					m2_req.en    = 1'b1;
					m2_req.we    = 1'b1;
					m2_req.addr  = mem_idx(imm_s1 + 16'd1);
					m2_req.wdata = gpr_q.h;
				end
				OP_XCHG: begin
					gpr_n.d = gpr_q.h;
					gpr_n.h = gpr_q.d;
					gpr_n.e = gpr_q.l;
					gpr_n.l = gpr_q.e;
				end
				OP_STA, OP_STAX, OP_OUT: begin
					gpr_n = gpr_q;   // store done at accept
				end
				OP_HLT: begin
					st_n = ST_HALT;
				end
				default: begin
					st_n = ST_FAULT;
				end
			endcase
		end
	end

	assign s1_done  = vld_s1 && s1_last && (!out_vld_q || result.ready);
	assign s1_adv   = vld_s1 && !s1_last;
	assign in_ready = !clr_busy && (!vld_s1 || (s1_done && !port_busy));
	assign accept   = instr.valid && in_ready;

	// ---------------------------------------------------------------------
	// first memory access of the incoming word; register operands are taken
	// from the execute results, so the word in s1 forwards into it
	// ---------------------------------------------------------------------
	always_comb begin
		logic [15:0] hl_n;
		logic [15:0] bc_n;
		logic [15:0] de_n;
		hl_n   = {gpr_n.h, gpr_n.l};
		bc_n   = {gpr_n.b, gpr_n.c};
		de_n   = {gpr_n.d, gpr_n.e};
		m1_req = '0;
		if (st_n == ST_RUN) begin
			case (op_t'(instr.op))
				OP_MOV: begin
					if (instr.dest_reg != instr.src_reg) begin
						if (instr.src_reg == R_M) begin
							m1_req.en   = 1'b1;
							m1_req.addr = mem_idx(hl_n);
						end else if (instr.dest_reg == R_M) begin
							m1_req.en    = 1'b1;
							m1_req.we    = 1'b1;
							m1_req.addr  = mem_idx(hl_n);
							m1_req.wdata = get_reg(gpr_n, instr.src_reg);
						end
					end
				end
				OP_MVI: begin
					if (instr.dest_reg == R_M) begin
						m1_req.en    = 1'b1;
						m1_req.we    = 1'b1;
						m1_req.addr  = mem_idx(hl_n);
						m1_req.wdata = instr.immediate[7:0];
					end
				end
				OP_LDA, OP_LHLD: begin
					m1_req.en   = 1'b1;
					m1_req.addr = mem_idx(instr.immediate);
				end
				OP_STA: begin
					m1_req.en    = 1'b1;
					m1_req.we    = 1'b1;
					m1_req.addr  = mem_idx(instr.immediate);
					m1_req.wdata = gpr_n.a;
				end
				OP_SHLD: begin
					m1_req.en    = 1'b1;
					m1_req.we    = 1'b1;
					m1_req.addr  = mem_idx(instr.immediate);
					m1_req.wdata = gpr_n.l;
				end
				OP_LDAX, OP_STAX: begin
					if (instr.reg_pair inside {PAIR_BC, PAIR_DE}) begin
						m1_req.en    = 1'b1;
						m1_req.we    = (op_t'(instr.op) == OP_STAX);
						m1_req.addr  = mem_idx((instr.reg_pair == PAIR_BC) ? bc_n : de_n);
						m1_req.wdata = gpr_n.a;
					end
				end
				OP_IN: begin
					m1_req.en   = 1'b1;
					m1_req.addr = mem_idx({8'h00, instr.immediate[7:0]});
				end
				OP_OUT: begin
					m1_req.en    = 1'b1;
					m1_req.we    = 1'b1;
					m1_req.addr  = mem_idx({8'h00, instr.immediate[7:0]});
					m1_req.wdata = gpr_n.a;
				end
				default: begin
					m1_req = '0;
				end
			endcase
		end
	end

	// single port: accept never coincides with a second access (port_busy)
	always_comb begin
		if (accept) begin
			mreq = m1_req;
		end else if (s1_adv || (s1_done && port_busy)) begin
			mreq = m2_req;
		end else begin
			mreq = '0;
		end
	end

	// ---------------------------------------------------------------------
	// registers
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gpr_q <= '0;
			sp_q  <= '0;
			st_q  <= ST_RUN;
		end else if (s1_done || s1_adv) begin
			gpr_q <= gpr_n;
			sp_q  <= sp_n;
			st_q  <= st_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			ph_s1  <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
			ph_s1  <= 1'b0;
		end else if (s1_done) begin
			vld_s1 <= 1'b0;
			ph_s1  <= 1'b0;
		end else if (s1_adv) begin
			ph_s1  <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= instr.op;
			dst_s1  <= instr.dest_reg;
			src_s1  <= instr.src_reg;
			pair_s1 <= instr.reg_pair;
			imm_s1  <= instr.immediate;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (s1_done) begin
			out_vld_q <= 1'b1;
		end else if (result.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_done) begin
			out_gpr_q <= gpr_n;
			out_sp_q  <= sp_n;
			out_st_q  <= st_n;
		end
	end

	assign instr.ready      = in_ready;
	assign result.valid     = out_vld_q;
	assign result.reg_a     = out_gpr_q.a;
	assign result.reg_b     = out_gpr_q.b;
	assign result.reg_c     = out_gpr_q.c;
	assign result.reg_d     = out_gpr_q.d;
	assign result.reg_e     = out_gpr_q.e;
	assign result.reg_h     = out_gpr_q.h;
	assign result.reg_l     = out_gpr_q.l;
	assign result.stack_ptr = out_sp_q;
	assign result.status    = out_st_q;

	// ---------------------------------------------------------------------
	// checks
	// ---------------------------------------------------------------------
`include "cpu_data_transfer_unit_macros.svh"

	`CDTU_ASSERT_IMPL(a_port_free, clk, arst_n, vld_s1 && port_busy, !instr.ready)
	`CDTU_ASSERT_IMPL(a_no_overwrite, clk, arst_n, out_vld_q && !result.ready, !s1_done)
	`CDTU_ASSERT_NEXT(a_stop_sticky, clk, arst_n, st_q != ST_RUN, st_q == $past(st_q))
	`CDTU_ASSERT_IMPL(a_clear_idle, clk, arst_n, clr_busy, !instr.ready && !vld_s1)

endmodule

/* src/cdtu_dmem.sv */
module cdtu_dmem (
	input  logic              clk,
	input  logic              arst_n,
	input  cdtu_pkg::mem_req_t req,
	output logic [7:0]        rdata,
	output logic              busy
);
	import cdtu_pkg::*;

	logic [7:0] mem [MEM_DEPTH];
	logic       clr_q;
	maddr_t     clr_cnt_q;

	// zero sweep after reset, one entry per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
		end else if (clr_q) begin
			clr_cnt_q <= clr_cnt_q + maddr_t'(1);
			if (clr_cnt_q == MEM_AW'(MEM_DEPTH - 1)) begin
				clr_q <= 1'b0;
			end
		end
	end

	// rdata only moves on a read, so it holds across stalls
	always_ff @(posedge clk) begin
		if (clr_q) begin
			mem[clr_cnt_q] <= 8'h00;
		end else if (req.en) begin
			if (req.we) begin
				mem[req.addr] <= req.wdata;
			end else begin
				rdata <= mem[req.addr];
			end
		end
	end

	assign busy = clr_q;

endmodule

/* test/cdtu_checker.sv */
module cdtu_checker
	import cdtu_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	cdtu_instr_if  instr,
	cdtu_result_if result,
	output int     fail_count,
	output int     words_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [7:0]  a;
		logic [7:0]  b;
		logic [7:0]  c;
		logic [7:0]  d;
		logic [7:0]  e;
		logic [7:0]  h;
		logic [7:0]  l;
		logic [15:0] sp;
		status_t     status;
	} cpu_state_t;

	// shadow copy of the unit
	logic [7:0]  gpr [7];
	logic [15:0] sp_model;
	logic [7:0]  mem_model [MEM_DEPTH];
	status_t     run_state;

	cpu_state_t  state_q [$];

	function automatic int mem_slot(logic [15:0] addr);
		return int'(addr) % MEM_DEPTH;
	endfunction

	// register or M operand (M goes through HL)
	function automatic void store_operand(logic [2:0] code, logic [7:0] v);
		if (code == R_M)
			mem_model[mem_slot({gpr[R_H], gpr[R_L]})] = v;
		else
			gpr[code] = v;
	endfunction

	function automatic cpu_state_t execute_word(logic [3:0] op, logic [2:0] dst,
			logic [2:0] src, logic [2:0] pair, logic [15:0] imm);
		logic [15:0] hl;
		logic [15:0] imm_next;
		logic [7:0]  tmp;
		cpu_state_t  snap;
		hl       = {gpr[R_H], gpr[R_L]};
		imm_next = imm + 16'd1;
		// halted or faulted: word is swallowed, state reported as is
		if (run_state == ST_RUN) begin
			case (op)
				OP_MOV: begin
					if (dst != src)
						store_operand(dst, (src == R_M) ? mem_model[mem_slot(hl)] : gpr[src]);
				end
				OP_MVI: store_operand(dst, imm[7:0]);
				OP_LDA: gpr[R_A] = mem_model[mem_slot(imm)];
				OP_STA: mem_model[mem_slot(imm)] = gpr[R_A];
				OP_LDAX: begin
					if (pair == PAIR_BC)
						gpr[R_A] = mem_model[mem_slot({gpr[R_B], gpr[R_C]})];
					else if (pair == PAIR_DE)
						gpr[R_A] = mem_model[mem_slot({gpr[R_D], gpr[R_E]})];
				end
				OP_STAX: begin
					if (pair == PAIR_BC)
						mem_model[mem_slot({gpr[R_B], gpr[R_C]})] = gpr[R_A];
					else if (pair == PAIR_DE)
						mem_model[mem_slot({gpr[R_D], gpr[R_E]})] = gpr[R_A];
				end
				OP_LXI: begin
					case (pair)
						PAIR_BC: begin
							gpr[R_B] = imm[15:8];
							gpr[R_C] = imm[7:0];
						end
						PAIR_DE: begin
							gpr[R_D] = imm[15:8];
							gpr[R_E] = imm[7:0];
						end
						PAIR_HL: begin
							gpr[R_H] = imm[15:8];
							gpr[R_L] = imm[7:0];
						end
						PAIR_SP: sp_model = imm;
						default: ;
					endcase
				end
				// second byte address wraps at 16 bits before the depth wrap
				OP_LHLD: begin
					gpr[R_L] = mem_model[mem_slot(imm)];
					gpr[R_H] = mem_model[mem_slot(imm_next)];
				end
				OP_SHLD: begin
					mem_model[mem_slot(imm)]      = gpr[R_L];
					mem_model[mem_slot(imm_next)] = gpr[R_H];
				end
				OP_XCHG: begin
					tmp      = gpr[R_D];
					gpr[R_D] = gpr[R_H];
					gpr[R_H] = tmp;
					tmp      = gpr[R_E];
					gpr[R_E] = gpr[R_L];
					gpr[R_L] = tmp;
				end
				OP_OUT: mem_model[mem_slot({8'h00, imm[7:0]})] = gpr[R_A];
				OP_IN: gpr[R_A] = mem_model[mem_slot({8'h00, imm[7:0]})];
				OP_HLT: run_state = ST_HALT;
				default: run_state = ST_FAULT;
			endcase
		end
		snap = '{gpr[R_A], gpr[R_B], gpr[R_C], gpr[R_D], gpr[R_E], gpr[R_H], gpr[R_L],
			sp_model, run_state};
		return snap;
	endfunction

	function automatic void check_field(string name, int want, int got);
		if (want != got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		cpu_state_t want;
		if (!arst_n) begin
			for (int i = 0; i < 7; i++)
				gpr[i] = '0;
			for (int i = 0; i < MEM_DEPTH; i++)
				mem_model[i] = '0;
			sp_model   = '0;
			run_state  = ST_RUN;
			state_q.delete();
			fail_count = 0;
		end else begin
			if (result.valid && result.ready) begin
				if (state_q.size() == 0) begin
					$error("result word with no instruction outstanding");
					fail_count++;
				end else begin
					want = state_q.pop_front();
					check_field("reg_a", want.a, result.reg_a);
					check_field("reg_b", want.b, result.reg_b);
					check_field("reg_c", want.c, result.reg_c);
					check_field("reg_d", want.d, result.reg_d);
					check_field("reg_e", want.e, result.reg_e);
					check_field("reg_h", want.h, result.reg_h);
					check_field("reg_l", want.l, result.reg_l);
					check_field("stack_ptr", want.sp, result.stack_ptr);
					check_field("status", want.status, result.status);
				end
			end
			if (instr.valid && instr.ready)
				state_q = {state_q, execute_word(instr.op, instr.dest_reg, instr.src_reg,
					instr.reg_pair, instr.immediate)};
		end
		words_pending = state_q.size();
	end

endmodule

/* test/tb_top.sv */
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import cdtu_pkg::*;

	localparam int LIMIT_CYCLES   = 400_000;  // sweep + ~1.2k words at worst-case gaps, x3
	localparam int RANDOM_WORDS   = 1175;
	localparam int TAIL_WORDS     = 12;       // words sent after the stop, all ignored
	localparam int BACKLOG_AT     = 400;      // words sent before the long result stall
	localparam int BACKLOG_CYCLES = 300;
	localparam int DRAIN_CYCLES   = 16;
	localparam int OP_CODE_MAX    = 15;

	// pair codes the unit must ignore
	localparam logic [2:0] PAIR_BAD_LO = 3'd4;
	localparam logic [2:0] PAIR_BAD_HI = 3'd7;

	logic clk = 1'b0;
	logic arst_n;
	int   fail_count;
	int   words_pending;
	int   words_sent = 0;

	always #10 clk = ~clk;

	cdtu_instr_if  instr_ch ();
	cdtu_result_if result_ch ();

	cpu_data_transfer_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.instr  (instr_ch),
		.result (result_ch)
	);

	cdtu_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.instr         (instr_ch),
		.result        (result_ch),
		.fail_count    (fail_count),
		.words_pending (words_pending)
	);

	// Mostly back-to-back, some short gaps, the odd long one.
	function automatic int idle_len();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 65)
			return 0;
		if (roll < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// One window in four runs both sides flat out.
	function automatic bit calm_window();
		return ((words_sent / 128) % 4) == 1;
	endfunction

	// Addresses cluster on a few hot offsets so loads mostly hit bytes that
	// were stored earlier. Random upper nibble exercises the depth wrap;
	// 0xFFFF hits the 16-bit wrap of the LHLD/SHLD second byte. Low bytes
	// 0x00/0x01/0xFF make IN/OUT ports alias with LDA/STA locations.
	function automatic logic [15:0] pick_addr();
		logic [11:0] hot [8] = '{12'h000, 12'h001, 12'h0FF, 12'hFFF,
			12'hFFE, 12'h123, 12'h124, 12'h800};
		int roll;
		roll = $urandom_range(0, 9);
		if (roll < 6)
			return {4'($urandom()), hot[$urandom_range(0, 7)]};
		if (roll < 7)
			return 16'hFFFF;
		return 16'($urandom());
	endfunction

	// Offer one word, hold it until taken, then maybe idle. valid is only
	// dropped when a gap follows, so it never toggles within one step.
	task automatic send_word(input logic [3:0] op, input logic [2:0] dst,
			input logic [2:0] src, input logic [2:0] pair, input logic [15:0] imm);
		int gap;
		instr_ch.valid     <= 1'b1;
		instr_ch.op        <= op;
		instr_ch.dest_reg  <= dst;
		instr_ch.src_reg   <= src;
		instr_ch.reg_pair  <= pair;
		instr_ch.immediate <= imm;
		do @(posedge clk); while (!instr_ch.ready);
		words_sent++;
		gap = calm_window() ? 0 : idle_len();
		if (gap > 0) begin
			instr_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// any_op=0: only the twelve transfer ops, so the unit keeps running.
	// any_op=1: full opcode space, used once the unit has stopped.
	task automatic send_random(input bit any_op);
		logic [3:0]  op;
		logic [2:0]  dst;
		logic [2:0]  src;
		logic [2:0]  pair;
		logic [15:0] imm;
		op   = any_op ? 4'($urandom_range(0, OP_CODE_MAX)) : 4'($urandom_range(0, int'(OP_IN)));
		dst  = 3'($urandom_range(0, int'(R_M)));
		// src is forced to dst one time in ten, so same-register MOV shows up about one time in five
		src  = ($urandom_range(0, 9) == 0) ? dst : 3'($urandom_range(0, int'(R_M)));
		// invalid pairs an eighth of the time
		pair = ($urandom_range(0, 3) == 0) ? 3'($urandom()) : 3'($urandom_range(0, int'(PAIR_SP)));
		if (op == OP_MVI || op == OP_MOV || op == OP_XCHG)
			imm = 16'($urandom());
		else
			imm = pick_addr();
		send_word(op, dst, src, pair, imm);
	endtask

	initial begin : stimulus
		arst_n              = 1'b0;
		instr_ch.valid     <= 1'b0;
		instr_ch.op        <= '0;
		instr_ch.dest_reg  <= '0;
		instr_ch.src_reg   <= '0;
		instr_ch.reg_pair  <= '0;
		instr_ch.immediate <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		// The memory clear after reset keeps instr.ready low; send_word just waits.

		// -- directed: extremes and every transfer op --
		send_word(OP_LXI,  R_A, R_A, PAIR_SP, 16'hFFFF);
		send_word(OP_LXI,  R_A, R_A, PAIR_HL, 16'hFFFF);
		send_word(OP_MVI,  R_M, R_A, PAIR_BC, 16'hFF80);  // M at top of memory, high byte dropped
		send_word(OP_MVI,  R_A, R_A, PAIR_BC, 16'h12FF);
		send_word(OP_SHLD, R_A, R_A, PAIR_BC, 16'hFFFF);  // second byte wraps to 0
		send_word(OP_LXI,  R_A, R_A, PAIR_HL, 16'h0000);
		send_word(OP_LHLD, R_A, R_A, PAIR_BC, 16'hFFFF);
		send_word(OP_LXI,  R_A, R_A, PAIR_BC, 16'h1234);
		send_word(OP_LXI,  R_A, R_A, PAIR_DE, 16'hF00F);
		send_word(OP_STAX, R_A, R_A, PAIR_BC, 16'h0000);
		send_word(OP_MVI,  R_A, R_A, PAIR_BC, 16'hFF00);
		send_word(OP_LDAX, R_A, R_A, PAIR_BC, 16'h0000);
		send_word(OP_STAX, R_A, R_A, PAIR_DE, 16'h0000);
		// pairs outside the legal set must leave everything alone
		send_word(OP_LDAX, R_A, R_A, PAIR_HL, 16'h0000);
		send_word(OP_STAX, R_A, R_A, PAIR_BAD_HI, 16'h0000);
		send_word(OP_LXI,  R_A, R_A, PAIR_BAD_LO, 16'hAAAA);
		send_word(OP_STA,  R_A, R_A, PAIR_BC, 16'h0000);
		send_word(OP_LDA,  R_A, R_A, PAIR_BC, 16'hF000);  // alias of address 0
		send_word(OP_OUT,  R_A, R_A, PAIR_BC, 16'hFF01);  // port is the low byte only
		send_word(OP_IN,   R_A, R_A, PAIR_BC, 16'h0001);
		send_word(OP_XCHG, R_A, R_A, PAIR_BC, 16'h0000);
		send_word(OP_MOV,  R_M, R_M, PAIR_BC, 16'h0000);  // same operand: no-op
		send_word(OP_MOV,  R_A, R_A, PAIR_BC, 16'h0000);
		send_word(OP_MOV,  R_B, R_M, PAIR_BC, 16'h0000);
		send_word(OP_MOV,  R_M, R_A, PAIR_BC, 16'h0000);
		send_word(OP_MOV,  R_H, R_L, PAIR_BC, 16'h0000);

		// -- random transfers, unit stays running --
		repeat (RANDOM_WORDS) send_random(1'b0);

		// -- stop the unit one way or the other; only one per run since reset
		// is never reapplied. Everything after must be swallowed. --
		if ($urandom_range(0, 1) == 0)
			send_word(OP_HLT, R_A, R_A, PAIR_BC, pick_addr());
		else
			send_word(4'($urandom_range(int'(OP_HLT) + 1, OP_CODE_MAX)), R_A, R_A, PAIR_BC,
				pick_addr());
		repeat (TAIL_WORDS) send_random(1'b1);
		instr_ch.valid <= 1'b0;

		// sample the checker's counters away from the clock edge it updates on
		@(negedge clk);
		while (words_pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// Result side: random ready pattern plus one long stall partway through
	// so the unit backs up and drops instr.ready while words keep coming.
	initial begin : result_side
		int  run;
		int  hold;
		bit  backlog_done;
		backlog_done     = 1'b0;
		result_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (!backlog_done && words_sent >= BACKLOG_AT) begin
				result_ch.ready <= 1'b0;
				repeat (BACKLOG_CYCLES) @(posedge clk);
				backlog_done = 1'b1;
			end else begin
				run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 12);
				result_ch.ready <= 1'b1;
				repeat (run) @(posedge clk);
				hold = calm_window() ? 0 : idle_len();
				if (hold > 0) begin
					result_ch.ready <= 1'b0;
					repeat (hold) @(posedge clk);
				end
			end
		end
	end

	// hard stop if the handshakes hang
	initial begin : watchdog
		repeat (LIMIT_CYCLES) @(posedge clk);
		$display("end of test: mismatches");
		$finish;
	end

endmodule
